// ===== rtl/core/dtrc_pkg.sv =====
// Shared types, constants and helper functions for the thruster ramp controller.
`default_nettype none

package dtrc_pkg;

  localparam logic [10:0] NEUTRAL_US  = 11'd1500;
  localparam logic [10:0] PULSE_MIN   = 11'd1000;
  localparam logic [10:0] PULSE_MAX   = 11'd2000;
  localparam logic [10:0] MAX_STEP_US = 11'd500;
  // product of elapsed ms and rate at which the step reaches the clamp
  localparam logic [31:0] STEP_CLAMP_TENTHS = 32'd5000;
  // 6554 / 2^16 approximates 1/10, exact below 10900
  localparam logic [13:0] RECIP10 = 14'd6554;

  localparam logic [6:0]  THROTTLE_MAX   = 7'd100;
  localparam logic [6:0]  THROTTLE_RESET = 7'd50;
  localparam logic [15:0] RAMP_RESET     = 16'd20;
  localparam logic [15:0] ARM_TIME_RESET = 16'd3000;

  localparam int unsigned ADDR_W = 4;

  typedef enum logic [1:0] {
    REG_THROTTLE = 2'd0,
    REG_RAMP     = 2'd1,
    REG_ARM_TIME = 2'd2
  } reg_e;

  typedef enum logic [2:0] {
    FUNC_TICK     = 3'd0,
    FUNC_NAV      = 3'd1,
    FUNC_STOP     = 3'd2,
    FUNC_PT_START = 3'd3,
    FUNC_PT_END   = 3'd4
  } func_e;

  typedef enum logic [2:0] {
    NAV_HALT = 3'd0,
    NAV_FWD  = 3'd1,
    NAV_REV  = 3'd2,
    NAV_CW   = 3'd3,
    NAV_CCW  = 3'd4
  } nav_e;

  typedef enum logic [1:0] {
    PIN_NONE = 2'd0,
    PIN_PORT = 2'd1,
    PIN_STBD = 2'd2
  } pin_e;

  typedef struct packed {
    logic [2:0]  func;
    logic [15:0] elapsed_ms;
    logic [2:0]  nav_cmd;
    logic [1:0]  pin_select;
  } cmd_t;

  typedef struct packed {
    logic [10:0] port_pulse_us;
    logic [10:0] stbd_pulse_us;
    logic [10:0] port_goal_us;
    logic [10:0] stbd_goal_us;
    logic        is_armed;
    logic [15:0] arm_left_ms;
    logic        in_pin_test;
    logic        port_forced_high;
    logic        stbd_forced_high;
    logic [2:0]  current_nav;
    logic [15:0] stop_count;
  } rpt_t;

  typedef struct packed {
    logic [6:0]  throttle;
    logic [15:0] ramp;
    logic [3:0]  ramp_m10;
    logic [15:0] arm_time;
    logic        throttle_wr;
    logic [6:0]  throttle_wdata;
  } cfg_t;

  // item held in the input register
  typedef struct packed {
    logic        valid;
    logic [2:0]  func;
    logic [15:0] elapsed_ms;
    logic [2:0]  nav;
    logic [1:0]  pin_select;
    logic [31:0] prod;
    logic [3:0]  prod_m10;
  } stage_t;

  typedef struct packed {
    logic [10:0] port;
    logic [10:0] stbd;
  } goals_t;

  // x mod 10: mod 5 from the nibble sum (16 = 1 mod 5), parity from bit 0
  function automatic logic [3:0] mod10_16(input logic [15:0] x);
    logic [5:0] s;
    logic [4:0] t;
    logic [2:0] m5;
    logic [3:0] r;
    s = 6'(x[3:0]) + 6'(x[7:4]) + 6'(x[11:8]) + 6'(x[15:12]);
    t = 5'(s[5:4]) + 5'(s[3:0]);
    if (t >= 5'd15) begin
      m5 = 3'(t - 5'd15);
    end else if (t >= 5'd10) begin
      m5 = 3'(t - 5'd10);
    end else if (t >= 5'd5) begin
      m5 = 3'(t - 5'd5);
    end else begin
      m5 = 3'(t);
    end
    r = {1'b0, m5};
    if (r[0] != x[0]) begin
      r = r + 4'd5;
    end
    return r;
  endfunction

  function automatic goals_t mix(input logic [2:0] nav, input logic [6:0] thr);
    logic [10:0] d;
    logic [10:0] fwd;
    logic [10:0] rev;
    goals_t g;
    d   = 11'({thr, 2'b00}) + 11'(thr);
    fwd = NEUTRAL_US + d;
    rev = NEUTRAL_US - d;
    case (nav)
      NAV_FWD: begin g.port = fwd; g.stbd = fwd; end
      NAV_REV: begin g.port = rev; g.stbd = rev; end
      NAV_CW:  begin g.port = fwd; g.stbd = rev; end
      NAV_CCW: begin g.port = rev; g.stbd = fwd; end
      default: begin g.port = NEUTRAL_US; g.stbd = NEUTRAL_US; end
    endcase
    return g;
  endfunction

  function automatic logic [10:0] slew(input logic [10:0] cur, input logic [10:0] goal,
                                       input logic [10:0] step);
    logic [10:0] r;
    if (cur < goal) begin
      r = ((goal - cur) <= step) ? goal : cur + step;
    end else if (cur > goal) begin
      r = ((cur - goal) <= step) ? goal : cur - step;
    end else begin
      r = cur;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/dtrc_regs.sv =====
// Configuration register bank on the APB-style port.
`default_nettype none

module dtrc_regs (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [dtrc_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                  pwdata,
  output logic      [31:0]                  prdata,
  output logic                              pready,
  output dtrc_pkg::cfg_t                    cfg
);

  logic [6:0]  throttle;
  logic [15:0] ramp;
  logic [3:0]  ramp_m10;
  logic [15:0] arm_time;
  logic        wr;
  logic [1:0]  idx;
  logic [6:0]  thr_w;
  logic [15:0] ramp_w;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite & pready;
  assign idx    = paddr[3:2];
  assign thr_w  = (pwdata[6:0] > dtrc_pkg::THROTTLE_MAX) ? dtrc_pkg::THROTTLE_MAX
                                                         : pwdata[6:0];
  assign ramp_w = (pwdata[15:0] == 16'd0) ? 16'd1 : pwdata[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      throttle <= dtrc_pkg::THROTTLE_RESET;
      ramp     <= dtrc_pkg::RAMP_RESET;
      ramp_m10 <= dtrc_pkg::mod10_16(dtrc_pkg::RAMP_RESET);
      arm_time <= dtrc_pkg::ARM_TIME_RESET;
    end else if (wr) begin
      case (idx)
        dtrc_pkg::REG_THROTTLE: throttle <= thr_w;
        dtrc_pkg::REG_RAMP: begin
          ramp     <= ramp_w;
          ramp_m10 <= dtrc_pkg::mod10_16(ramp_w);
        end
        dtrc_pkg::REG_ARM_TIME: arm_time <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      dtrc_pkg::REG_THROTTLE: prdata = 32'(throttle);
      dtrc_pkg::REG_RAMP:     prdata = 32'(ramp);
      dtrc_pkg::REG_ARM_TIME: prdata = 32'(arm_time);
      default:                prdata = 32'd0;
    endcase
  end

  always_comb begin
    cfg.throttle       = throttle;
    cfg.ramp           = ramp;
    cfg.ramp_m10       = ramp_m10;
    cfg.arm_time       = arm_time;
    cfg.throttle_wr    = wr && (idx == dtrc_pkg::REG_THROTTLE);
    cfg.throttle_wdata = thr_w;
  end

endmodule

`default_nettype wire

// ===== rtl/core/dtrc_prep.sv =====
// Input register: takes a command item and precomputes the slew product.
`default_nettype none

module dtrc_prep (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cmd_valid,
  input  wire dtrc_pkg::cmd_t cmd,
  output logic                cmd_stall,
  input  wire dtrc_pkg::cfg_t cfg,
  input  wire logic           take,
  output dtrc_pkg::stage_t    stg
);

  logic        accept;
  logic [2:0]  nav_s;
  logic [31:0] prod_next;
  logic [3:0]  dt_m10;
  logic [7:0]  small_prod;

  assign cmd_stall = stg.valid & ~take;
  assign accept    = cmd_valid & ~cmd_stall;

  assign nav_s      = (cmd.nav_cmd > dtrc_pkg::NAV_CCW) ? dtrc_pkg::NAV_HALT : cmd.nav_cmd;
  assign prod_next  = {16'd0, cmd.elapsed_ms} * {16'd0, cfg.ramp};
  // the product mod 10 follows from the operands mod 10
  assign dt_m10     = dtrc_pkg::mod10_16(cmd.elapsed_ms);
  assign small_prod = {4'd0, dt_m10} * {4'd0, cfg.ramp_m10};

  always_ff @(posedge clk) begin
    if (rst) begin
      stg.valid <= 1'b0;
    end else if (accept) begin
      stg.valid <= 1'b1;
    end else if (take) begin
      stg.valid <= 1'b0;
    end
    if (accept) begin
      stg.func       <= cmd.func;
      stg.elapsed_ms <= cmd.elapsed_ms;
      stg.nav        <= nav_s;
      stg.pin_select <= cmd.pin_select;
      stg.prod       <= prod_next;
      stg.prod_m10   <= dtrc_pkg::mod10_16({8'd0, small_prod});
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/dtrc_core.sv =====
// Controller state, per-item update and the result register.
`default_nettype none

module dtrc_core (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire dtrc_pkg::cfg_t   cfg,
  input  wire dtrc_pkg::stage_t stg,
  output logic                  take,
  output logic                  rpt_valid,
  input  wire logic             rpt_stall,
  output dtrc_pkg::rpt_t        rpt
);

  logic [10:0] port_pulse, stbd_pulse, port_goal, stbd_goal;
  logic [2:0]  nav_stored;
  logic        armed;
  logic [15:0] arm_elapsed;
  logic [3:0]  rem;
  logic        pin_test;
  logic [1:0]  pin_levels;
  logic [15:0] stops;

  logic [10:0] port_pulse_next, stbd_pulse_next, port_goal_next, stbd_goal_next;
  logic [2:0]  nav_stored_next;
  logic        armed_next;
  logic [15:0] arm_elapsed_next;
  logic [3:0]  rem_next;
  logic        pin_test_next;
  logic [1:0]  pin_levels_next;
  logic [15:0] stops_next;
  logic [15:0] left;

  logic        fire;
  logic [4:0]  rem_sum;
  logic        carry;
  logic [26:0] recip_prod;
  logic [10:0] step_raw;
  logic [10:0] step;
  logic [16:0] ae_sum;
  dtrc_pkg::goals_t nav_goals;
  dtrc_pkg::goals_t cfg_goals;

  assign take = ~rpt_valid | ~rpt_stall;
  assign fire = stg.valid & take;

  // floor((rem + prod) / 10) = floor(prod / 10) + carry of the low digits
  assign rem_sum    = 5'(rem) + 5'(stg.prod_m10);
  assign carry      = rem_sum >= 5'd10;
  assign recip_prod = 27'(stg.prod[12:0]) * 27'(dtrc_pkg::RECIP10);
  assign step_raw   = recip_prod[26:16] + 11'(carry);
  assign ae_sum     = {1'b0, arm_elapsed} + {1'b0, stg.elapsed_ms};
  assign nav_goals  = dtrc_pkg::mix(stg.nav, cfg.throttle);
  assign cfg_goals  = dtrc_pkg::mix(nav_stored, cfg.throttle_wdata);

  always_comb begin
    if (stg.prod >= dtrc_pkg::STEP_CLAMP_TENTHS || step_raw > dtrc_pkg::MAX_STEP_US) begin
      step = dtrc_pkg::MAX_STEP_US;
    end else begin
      step = step_raw;
    end
  end

  always_comb begin
    port_pulse_next  = port_pulse;
    stbd_pulse_next  = stbd_pulse;
    port_goal_next   = port_goal;
    stbd_goal_next   = stbd_goal;
    nav_stored_next  = nav_stored;
    armed_next       = armed;
    arm_elapsed_next = arm_elapsed;
    rem_next         = rem;
    pin_test_next    = pin_test;
    pin_levels_next  = pin_levels;
    stops_next       = stops;
    case (stg.func)
      dtrc_pkg::FUNC_TICK: begin
        if (!pin_test) begin
          if (!armed) begin
            arm_elapsed_next = ae_sum[16] ? 16'hFFFF : ae_sum[15:0];
            armed_next       = arm_elapsed_next >= cfg.arm_time;
          end else if (stg.elapsed_ms != 16'd0) begin
            rem_next        = carry ? 4'(rem_sum - 5'd10) : rem_sum[3:0];
            port_pulse_next = dtrc_pkg::slew(port_pulse, port_goal, step);
            stbd_pulse_next = dtrc_pkg::slew(stbd_pulse, stbd_goal, step);
          end
        end
      end
      dtrc_pkg::FUNC_NAV: begin
        nav_stored_next = stg.nav;
        if (armed) begin
          port_goal_next = nav_goals.port;
          stbd_goal_next = nav_goals.stbd;
        end else begin
          port_goal_next = dtrc_pkg::NEUTRAL_US;
          stbd_goal_next = dtrc_pkg::NEUTRAL_US;
        end
      end
      dtrc_pkg::FUNC_STOP: begin
        port_pulse_next = dtrc_pkg::NEUTRAL_US;
        stbd_pulse_next = dtrc_pkg::NEUTRAL_US;
        port_goal_next  = dtrc_pkg::NEUTRAL_US;
        stbd_goal_next  = dtrc_pkg::NEUTRAL_US;
        nav_stored_next = dtrc_pkg::NAV_HALT;
        stops_next      = stops + 16'd1;
      end
      dtrc_pkg::FUNC_PT_START: begin
        pin_test_next   = 1'b1;
        pin_levels_next = {stg.pin_select == dtrc_pkg::PIN_STBD,
                           stg.pin_select == dtrc_pkg::PIN_PORT};
      end
      dtrc_pkg::FUNC_PT_END: begin
        if (pin_test) begin
          pin_test_next    = 1'b0;
          pin_levels_next  = 2'b00;
          port_pulse_next  = dtrc_pkg::NEUTRAL_US;
          stbd_pulse_next  = dtrc_pkg::NEUTRAL_US;
          port_goal_next   = dtrc_pkg::NEUTRAL_US;
          stbd_goal_next   = dtrc_pkg::NEUTRAL_US;
          nav_stored_next  = dtrc_pkg::NAV_HALT;
          armed_next       = 1'b0;
          arm_elapsed_next = 16'd0;
        end
      end
      default: ;
    endcase
    if (armed_next || arm_elapsed_next >= cfg.arm_time) begin
      left = 16'd0;
    end else begin
      left = cfg.arm_time - arm_elapsed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      port_pulse  <= dtrc_pkg::NEUTRAL_US;
      stbd_pulse  <= dtrc_pkg::NEUTRAL_US;
      port_goal   <= dtrc_pkg::NEUTRAL_US;
      stbd_goal   <= dtrc_pkg::NEUTRAL_US;
      nav_stored  <= dtrc_pkg::NAV_HALT;
      armed       <= 1'b0;
      arm_elapsed <= 16'd0;
      rem         <= 4'd0;
      pin_test    <= 1'b0;
      pin_levels  <= 2'b00;
      stops       <= 16'd0;
    end else if (fire) begin
      port_pulse  <= port_pulse_next;
      stbd_pulse  <= stbd_pulse_next;
      port_goal   <= port_goal_next;
      stbd_goal   <= stbd_goal_next;
      nav_stored  <= nav_stored_next;
      armed       <= armed_next;
      arm_elapsed <= arm_elapsed_next;
      rem         <= rem_next;
      pin_test    <= pin_test_next;
      pin_levels  <= pin_levels_next;
      stops       <= stops_next;
    end else if (cfg.throttle_wr && armed) begin
      // throttle change re-mixes the stored command
      port_goal <= cfg_goals.port;
      stbd_goal <= cfg_goals.stbd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rpt_valid <= 1'b0;
    end else if (fire) begin
      rpt_valid <= 1'b1;
    end else if (!rpt_stall) begin
      rpt_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rpt.port_pulse_us    <= port_pulse_next;
      rpt.stbd_pulse_us    <= stbd_pulse_next;
      rpt.port_goal_us     <= port_goal_next;
      rpt.stbd_goal_us     <= stbd_goal_next;
      rpt.is_armed         <= armed_next;
      rpt.arm_left_ms      <= left;
      rpt.in_pin_test      <= pin_test_next;
      rpt.port_forced_high <= pin_levels_next[0];
      rpt.stbd_forced_high <= pin_levels_next[1];
      rpt.current_nav      <= nav_stored_next;
      rpt.stop_count       <= stops_next;
    end
  end

`ifndef SYNTHESIS
  a_pulse_range: assert property (@(posedge clk) disable iff (rst)
    port_pulse >= dtrc_pkg::PULSE_MIN && port_pulse <= dtrc_pkg::PULSE_MAX &&
    stbd_pulse >= dtrc_pkg::PULSE_MIN && stbd_pulse <= dtrc_pkg::PULSE_MAX)
    else $error("pulse out of range");
  a_neutral_unarmed: assert property (@(posedge clk) disable iff (rst)
    !armed |-> (port_pulse == dtrc_pkg::NEUTRAL_US && stbd_pulse == dtrc_pkg::NEUTRAL_US))
    else $error("pulse moved before arming");
  a_pin_test_freeze: assert property (@(posedge clk) disable iff (rst)
    (fire && stg.func == dtrc_pkg::FUNC_TICK && pin_test) |=>
      ($stable(port_pulse) && $stable(stbd_pulse) && $stable(arm_elapsed)))
    else $error("tick changed state during pin test");
  a_levels_in_test: assert property (@(posedge clk) disable iff (rst)
    pin_levels != 2'b00 |-> pin_test)
    else $error("pin levels forced outside pin test");
  a_rem_digit: assert property (@(posedge clk) disable iff (rst)
    rem <= 4'd9)
    else $error("tenths remainder out of range");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/differential_thruster_ramp_controller_core.sv =====
// Top level of the two-channel thruster ramp controller.
// Each command item (tick, navigation, stop, pin test start/end) yields one report item.
// An item is taken into the input register, where the 16x16 rate multiply runs; its report
// is registered when the state-update stage takes it. One item per cycle while reports are
// not stalled, through the input register and the single state-update stage (reciprocal
// divide-by-ten multiply and slew compare). A stalled report holds the output register and
// the state; the input register keeps taking items until both are full. Configuration writes
// take effect at once and are meant for idle periods; there is no clearing pass after reset.
`default_nettype none

module differential_thruster_ramp_controller_core (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cmd_valid,
  output logic                              cmd_stall,
  input  wire dtrc_pkg::cmd_t               cmd,
  output logic                              rpt_valid,
  input  wire logic                         rpt_stall,
  output dtrc_pkg::rpt_t                    rpt,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [dtrc_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                  pwdata,
  output logic      [31:0]                  prdata,
  output logic                              pready
);

  dtrc_pkg::cfg_t   cfg;
  dtrc_pkg::stage_t stg;
  logic             take;

  dtrc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dtrc_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_stall (cmd_stall),
    .cfg       (cfg),
    .take      (take),
    .stg       (stg)
  );

  dtrc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .stg       (stg),
    .take      (take),
    .rpt_valid (rpt_valid),
    .rpt_stall (rpt_stall),
    .rpt       (rpt)
  );

endmodule

`default_nettype wire
